// File: rtl/cau_pkg.sv
// types, codes and helpers shared by the complex arithmetic unit
package cau_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUOT_BITS     = 32;
    localparam int DEN_W         = 64;
    localparam int WIDE_W        = 66;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } cau_func_t;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_DZ  = 2'd1,
        STAT_OVF = 2'd2
    } cau_status_t;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [DATA_W-1:0]  a_re;
        logic signed [DATA_W-1:0]  a_im;
        logic signed [DATA_W-1:0]  b_re;
        logic signed [DATA_W-1:0]  b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  r_re;
        logic signed [DATA_W-1:0]  r_im;
        logic [1:0]                status;
    } cau_out_t;

    // clamp a wide signed value to 32 bits, msb of the result flags saturation
    function automatic logic [DATA_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic [DATA_W:0]          r;
        hi = WIDE_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(signed'(2'sd1));
        if (v > hi) begin
            r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/complex_arith_unit.sv
// complex add, subtract, multiply and divide on signed q16.16 pairs
// throughput: one transaction per cycle while the skid entry is empty; the restoring divider resolves one
// quotient bit per pipeline stage, QUOT_BITS stages per lane
// a two-entry output (register plus skid) lets input flow while a result waits
// reset (aresetn low, synchronous) clears all valid bits; no other state
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cau_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cau_out_t m_data
);

    localparam int RW = (DEN_W + FRAC_BITS > DEN_W + QUOT_BITS) ?
                        DEN_W + FRAC_BITS : DEN_W + QUOT_BITS;

    typedef struct packed {
        logic [RW-1:0]             rem_re;
        logic [RW-1:0]             rem_im;
        logic [QUOT_BITS-1:0]      q_re;
        logic [QUOT_BITS-1:0]      q_im;
        logic [DEN_W-1:0]          den;
        logic                      neg_re;
        logic                      neg_im;
        logic                      sat_re;
        logic                      sat_im;
        logic                      dz;
        logic [1:0]                func;
        logic signed [WIDE_W-1:0]  res_re;
        logic signed [WIDE_W-1:0]  res_im;
    } div_stage_t;

    logic ce;

    // stage 1: input register
    logic    p1_v_reg;
    cau_in_t p1_reg;

    // stage 2: products and add/sub
    logic                     p2_v_reg;
    logic [1:0]               p2_func_reg;
    logic signed [63:0]       p2_rr_reg, p2_ii_reg, p2_ri_reg, p2_ir_reg;
    logic signed [63:0]       p2_bb_reg, p2_cc_reg;
    logic signed [DATA_W:0]   p2_as_re_reg, p2_as_im_reg;
    logic signed [DATA_W:0]   p2_as_re_next, p2_as_im_next;

    // stage 3: sums of products
    logic                     p3_v_reg;
    logic [1:0]               p3_func_reg;
    logic signed [WIDE_W-1:0] p3_res_re_reg, p3_res_im_reg;
    logic signed [64:0]       p3_num_re_reg, p3_num_im_reg;
    logic [DEN_W-1:0]         p3_den_reg;
    logic signed [WIDE_W-1:0] p3_res_re_next, p3_res_im_next;
    logic signed [64:0]       p3_mre_next, p3_mim_next;

    // stage 4: magnitudes for the divider
    logic                     p4_v_reg;
    logic [1:0]               p4_func_reg;
    logic signed [WIDE_W-1:0] p4_res_re_reg, p4_res_im_reg;
    logic [RW-1:0]            p4_n_re_reg, p4_n_im_reg;
    logic                     p4_neg_re_reg, p4_neg_im_reg, p4_dz_reg;
    logic [DEN_W-1:0]         p4_den_reg;
    logic [64:0]              p4_abs_re_next, p4_abs_im_next;

    // divider stages, index 0 holds the range check
    logic       d_v_reg [0:QUOT_BITS];
    div_stage_t d_reg   [0:QUOT_BITS];
    div_stage_t d_next  [0:QUOT_BITS];

    // output register and skid
    logic     out_v_reg, skid_v_reg;
    cau_out_t out_reg, skid_reg, fin_next;

    assign ce      = !skid_v_reg;
    assign s_ready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end else if (ce) begin
            p1_v_reg <= s_valid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
    end

    always_comb begin
        if (p1_reg.func == FUNC_SUB) begin
            p2_as_re_next = p1_reg.a_re - p1_reg.b_re;
            p2_as_im_next = p1_reg.a_im - p1_reg.b_im;
        end else begin
            p2_as_re_next = p1_reg.a_re + p1_reg.b_re;
            p2_as_im_next = p1_reg.a_im + p1_reg.b_im;
        end
    end

    always_comb begin
        p3_mre_next = 65'(p2_rr_reg) - 65'(p2_ii_reg);
        p3_mim_next = 65'(p2_ri_reg) + 65'(p2_ir_reg);
        if (p2_func_reg == FUNC_MUL) begin
            p3_res_re_next = WIDE_W'(p3_mre_next >>> FRAC_BITS);
            p3_res_im_next = WIDE_W'(p3_mim_next >>> FRAC_BITS);
        end else begin
            p3_res_re_next = WIDE_W'(p2_as_re_reg);
            p3_res_im_next = WIDE_W'(p2_as_im_reg);
        end
    end

    always_comb begin
        p4_abs_re_next = p3_num_re_reg[64] ? 65'(-p3_num_re_reg) : 65'(p3_num_re_reg);
        p4_abs_im_next = p3_num_im_reg[64] ? 65'(-p3_num_im_reg) : 65'(p3_num_im_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p1_reg <= s_data;

            p2_func_reg  <= p1_reg.func;
            p2_rr_reg    <= p1_reg.a_re * p1_reg.b_re;
            p2_ii_reg    <= p1_reg.a_im * p1_reg.b_im;
            p2_ri_reg    <= p1_reg.a_re * p1_reg.b_im;
            p2_ir_reg    <= p1_reg.a_im * p1_reg.b_re;
            p2_bb_reg    <= p1_reg.b_re * p1_reg.b_re;
            p2_cc_reg    <= p1_reg.b_im * p1_reg.b_im;
            p2_as_re_reg <= p2_as_re_next;
            p2_as_im_reg <= p2_as_im_next;

            p3_func_reg   <= p2_func_reg;
            p3_res_re_reg <= p3_res_re_next;
            p3_res_im_reg <= p3_res_im_next;
            p3_num_re_reg <= 65'(p2_rr_reg) + 65'(p2_ii_reg);
            p3_num_im_reg <= 65'(p2_ir_reg) - 65'(p2_ri_reg);
            p3_den_reg    <= DEN_W'($unsigned(p2_bb_reg)) + DEN_W'($unsigned(p2_cc_reg));

            p4_func_reg   <= p3_func_reg;
            p4_res_re_reg <= p3_res_re_reg;
            p4_res_im_reg <= p3_res_im_reg;
            p4_n_re_reg   <= RW'(p4_abs_re_next[63:0]) << FRAC_BITS;
            p4_n_im_reg   <= RW'(p4_abs_im_next[63:0]) << FRAC_BITS;
            p4_neg_re_reg <= p3_num_re_reg[64];
            p4_neg_im_reg <= p3_num_im_reg[64];
            p4_dz_reg     <= (p3_den_reg == '0);
            p4_den_reg    <= p3_den_reg;
        end
    end

    // range check: a quotient of 2^32 or more saturates in any case
    always_comb begin
        d_next[0].rem_re = p4_n_re_reg;
        d_next[0].rem_im = p4_n_im_reg;
        d_next[0].q_re   = '0;
        d_next[0].q_im   = '0;
        d_next[0].den    = p4_den_reg;
        d_next[0].neg_re = p4_neg_re_reg;
        d_next[0].neg_im = p4_neg_im_reg;
        d_next[0].sat_re = p4_n_re_reg >= (RW'(p4_den_reg) << QUOT_BITS);
        d_next[0].sat_im = p4_n_im_reg >= (RW'(p4_den_reg) << QUOT_BITS);
        d_next[0].dz     = p4_dz_reg;
        d_next[0].func   = p4_func_reg;
        d_next[0].res_re = p4_res_re_reg;
        d_next[0].res_im = p4_res_im_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg[0] <= 1'b0;
        end else if (ce) begin
            d_v_reg[0] <= p4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg[0] <= d_next[0];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_div
        logic [RW-1:0] trial;
        logic          ge_re, ge_im;

        always_comb begin
            trial     = RW'(d_reg[k-1].den) << (QUOT_BITS - k);
            ge_re     = d_reg[k-1].rem_re >= trial;
            ge_im     = d_reg[k-1].rem_im >= trial;
            d_next[k] = d_reg[k-1];
            if (ge_re) begin
                d_next[k].rem_re = d_reg[k-1].rem_re - trial;
            end
            if (ge_im) begin
                d_next[k].rem_im = d_reg[k-1].rem_im - trial;
            end
            d_next[k].q_re[QUOT_BITS-k] = ge_re;
            d_next[k].q_im[QUOT_BITS-k] = ge_im;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_v_reg[k] <= 1'b0;
            end else if (ce) begin
                d_v_reg[k] <= d_v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    // final sign, saturation and status
    always_comb begin
        logic [QUOT_BITS:0]       qm_re, qm_im;
        logic signed [WIDE_W-1:0] v_re, v_im;
        logic [DATA_W:0]          s_re, s_im;
        qm_re = d_reg[QUOT_BITS].sat_re ? {1'b1, {QUOT_BITS{1'b0}}}
                                        : {1'b0, d_reg[QUOT_BITS].q_re};
        qm_im = d_reg[QUOT_BITS].sat_im ? {1'b1, {QUOT_BITS{1'b0}}}
                                        : {1'b0, d_reg[QUOT_BITS].q_im};
        if (d_reg[QUOT_BITS].func == FUNC_DIV) begin
            v_re = d_reg[QUOT_BITS].neg_re ? -$signed(WIDE_W'(qm_re)) : $signed(WIDE_W'(qm_re));
            v_im = d_reg[QUOT_BITS].neg_im ? -$signed(WIDE_W'(qm_im)) : $signed(WIDE_W'(qm_im));
        end else begin
            v_re = d_reg[QUOT_BITS].res_re;
            v_im = d_reg[QUOT_BITS].res_im;
        end
        s_re = sat32(v_re);
        s_im = sat32(v_im);
        if (d_reg[QUOT_BITS].func == FUNC_DIV && d_reg[QUOT_BITS].dz) begin
            fin_next.r_re   = '0;
            fin_next.r_im   = '0;
            fin_next.status = STAT_DZ;
        end else begin
            fin_next.r_re   = s_re[DATA_W-1:0];
            fin_next.r_im   = s_im[DATA_W-1:0];
            fin_next.status = (s_re[DATA_W] || s_im[DATA_W]) ? STAT_OVF : STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_ready) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end else if (d_v_reg[QUOT_BITS]) begin
            if (!out_v_reg || m_ready) begin
                out_v_reg <= 1'b1;
            end else begin
                skid_v_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (d_v_reg[QUOT_BITS]) begin
            if (!out_v_reg || m_ready) begin
                out_reg <= fin_next;
            end else begin
                skid_reg <= fin_next;
            end
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STAT_DZ) |-> (m_data.r_re == '0 && m_data.r_im == '0))
        else $error("divide by zero result is not zero");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STAT_OVF) |->
        (m_data.r_re == 32'sh7fffffff || m_data.r_re == 32'sh80000000 ||
         m_data.r_im == 32'sh7fffffff || m_data.r_im == 32'sh80000000))
        else $error("overflow status without a saturated part");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status != 2'd3))
        else $error("undefined status code");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled while output is empty");

    a_skid_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_v_reg && !m_ready) |=> (skid_v_reg && $stable(skid_reg)))
        else $error("skid entry lost during stall");
`endif

endmodule
